FILE: rtl/core/ush_pkg.sv
// ----------------------------------------------------------------------------
// ush_pkg: shared types and constants of the universal string hash
// Constants of the hash scheme, controller state, command and status
// structs, and the width of the shift-subtract reduction.
// ----------------------------------------------------------------------------
`default_nettype none

package ush_pkg;

  localparam int HASH_BITS_DEF = 16;
  localparam int TABLE_BITS    = 16;
  localparam int CHAR_BITS     = 8;
  localparam int STEP_BITS     = 15;

  localparam logic [TABLE_BITS-1:0] MULT_STEP   = 16'd27183;
  localparam logic [TABLE_BITS-1:0] MULT_START  = 16'd31415;
  localparam logic [TABLE_BITS-1:0] TABLE_RESET = 16'd919;
  localparam logic [TABLE_BITS-1:0] TABLE_MIN   = 16'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_RED,
    ST_DONE
  } ush_state_e;

  typedef struct packed {
    logic load_in;
    logic load_prod;
    logic reduce;
    logic commit;
  } ush_cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } ush_status_t;

  // dividend width: covers hash*mult + char and mult*step
  function automatic int red_width(int hb);
    int pw;
    int kw;
    pw = ((2 * hb > CHAR_BITS) ? 2 * hb : CHAR_BITS) + 1;
    kw = hb + STEP_BITS;
    return (pw > kw) ? pw : kw;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ush_ctrl.sv
// ----------------------------------------------------------------------------
// ush_ctrl: sequencer of the universal string hash
// Takes a character, starts the multiply, counts the reduction steps and
// commits the new state, holding a final result until the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

module ush_ctrl #(
  parameter int HASH_BITS = ush_pkg::HASH_BITS_DEF
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire ush_pkg::ush_status_t status_i,
  output ush_pkg::ush_cmd_t        cmd_o
);

  localparam int RED_W = ush_pkg::red_width(HASH_BITS);
  localparam int CNT_W = $clog2(RED_W);

  ush_pkg::ush_state_e state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ush_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ush_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = ush_pkg::ST_MUL;
        end
      end
      ush_pkg::ST_MUL: begin
        cmd_o.load_prod = 1'b1;
        cnt_d           = CNT_W'(RED_W - 1);
        state_d         = ush_pkg::ST_RED;
      end
      ush_pkg::ST_RED: begin
        cmd_o.reduce = 1'b1;
        if (cnt_q == '0) begin
          state_d = ush_pkg::ST_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ush_pkg::ST_DONE: begin
        if (!(status_i.last && status_i.out_busy)) begin
          cmd_o.commit = 1'b1;
          state_d      = ush_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ush_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/ush_datapath.sv
// ----------------------------------------------------------------------------
// ush_datapath: arithmetic of the universal string hash
// Hash and multiplier state, the two products, two parallel radix-2
// reductions, the table size register and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ush_datapath #(
  parameter int HASH_BITS = ush_pkg::HASH_BITS_DEF
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire ush_pkg::ush_cmd_t                cmd_i,
  output ush_pkg::ush_status_t                  status_o,
  input  wire  [ush_pkg::CHAR_BITS-1:0]         char_i,
  input  wire                                   last_i,
  input  wire                                   cfg_we_i,
  input  wire  [ush_pkg::TABLE_BITS-1:0]        cfg_data_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output logic [ush_pkg::TABLE_BITS-1:0]        out_data_o
);

  localparam int HW    = HASH_BITS;
  localparam int TB    = ush_pkg::TABLE_BITS;
  localparam int RED_W = ush_pkg::red_width(HASH_BITS);

  logic [TB-1:0]                  tsize_q;
  logic [HW-1:0]                  h_q, k_q;
  logic [ush_pkg::CHAR_BITS-1:0]  ch_q;
  logic                           last_q;
  logic [RED_W-1:0]               hdiv_q, kdiv_q;
  logic [TB-1:0]                  hr_q, kr_q;
  logic                           out_valid_q;
  logic [TB-1:0]                  out_q;

  logic [TB-1:0]                  mod_h, mod_k;
  logic [2*HW-1:0]                hmul;
  logic [HW+ush_pkg::STEP_BITS-1:0] kmul;
  logic [TB:0]                    ht, kt;
  logic [TB-1:0]                  hr_d, kr_d;
  logic [HW-1:0]                  h_new, k_new;

  assign mod_h = (tsize_q < ush_pkg::TABLE_MIN) ? ush_pkg::TABLE_MIN : tsize_q;
  assign mod_k = mod_h - 1'b1;

  assign hmul = h_q * k_q;
  assign kmul = k_q * ush_pkg::STEP_BITS'(ush_pkg::MULT_STEP);

  assign ht   = {hr_q, hdiv_q[RED_W-1]};
  assign kt   = {kr_q, kdiv_q[RED_W-1]};
  assign hr_d = (ht >= {1'b0, mod_h}) ? TB'(ht - {1'b0, mod_h}) : ht[TB-1:0];
  assign kr_d = (kt >= {1'b0, mod_k}) ? TB'(kt - {1'b0, mod_k}) : kt[TB-1:0];

  assign h_new = HW'(hr_q);
  assign k_new = HW'(kr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsize_q     <= ush_pkg::TABLE_RESET;
      h_q         <= '0;
      k_q         <= HW'(ush_pkg::MULT_START);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tsize_q <= cfg_data_i;
      end
      if (cmd_i.commit && last_q) begin
        h_q <= '0;
        k_q <= HW'(ush_pkg::MULT_START);
      end else if (cmd_i.commit) begin
        h_q <= h_new;
        k_q <= k_new;
      end
      if (cmd_i.commit && last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      ch_q   <= char_i;
      last_q <= last_i;
    end
    if (cmd_i.load_prod) begin
      hdiv_q <= RED_W'(hmul) + RED_W'(ch_q);
      kdiv_q <= RED_W'(kmul);
      hr_q   <= '0;
      kr_q   <= '0;
    end else if (cmd_i.reduce) begin
      hdiv_q <= hdiv_q << 1;
      kdiv_q <= kdiv_q << 1;
      hr_q   <= hr_d;
      kr_q   <= kr_d;
    end
    if (cmd_i.commit && last_q) begin
      out_q <= TB'(h_new);
    end
  end

  assign status_o.last     = last_q;
  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

`default_nettype wire

FILE: rtl/core/universal_string_hash.sv
// ----------------------------------------------------------------------------
// universal_string_hash: varying-multiplier string hash
// Top level: sequencer and datapath joined by command and status structs.
// ----------------------------------------------------------------------------
// Hashes a key one byte per transfer; tlast marks the final byte, after
// which the bucket index (below table_size) appears on the output stream
// and the hash restarts. Each byte goes through the bit-serial
// shift-subtract reductions of hash*mult+char mod M and mult*27183
// mod (M-1), which run side by side; the next byte is taken only once
// the last is committed. The finished hash waits in an output register
// while the next string is taken. table_size values below 2 act as 2.
// Write table_size only while the block is idle.
`default_nettype none

module universal_string_hash #(
  parameter int HASH_BITS = ush_pkg::HASH_BITS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] character
  input  wire         s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] hash_value
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [15:0] cfg_data_i      // table_size
);

  ush_pkg::ush_cmd_t    cmd;
  ush_pkg::ush_status_t status;

  assign cfg_ready_o = 1'b1;

  ush_ctrl #(
    .HASH_BITS (HASH_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ush_datapath #(
    .HASH_BITS (HASH_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .char_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

FILE: tb/tb_universal_string_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_universal_string_hash: self-checking bench for the string hash
// Sends key strings byte by byte on the input stream and checks each bucket
// index on the output stream against a cycle-free model of the hash or a
// typed value in the directed table, which comes first; then random strings
// over several table sizes, with and without random idling on both streams.
// ----------------------------------------------------------------------------

module tb_universal_string_hash;

  localparam int WATCHDOG_LIMIT    = 4000;
  localparam int DRAIN_CYCLES      = 60;
  localparam int ITEMS_PER_SETTING = 86;

  typedef enum logic {
    ROW_BYTE,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [15:0] value;
    logic        last;
    logic        chk;
    logic [15:0] bucket;
  } row_t;

  // value is the byte for ROW_BYTE, the table size for ROW_CFG
  localparam row_t DIRECTED [27] = '{
    '{ROW_BYTE, 16'd0,     1'b1, 1'b1, 16'd0},
    '{ROW_BYTE, 16'd255,   1'b1, 1'b1, 16'd255},
    '{ROW_BYTE, 16'd97,    1'b0, 1'b0, 16'd0},
    '{ROW_BYTE, 16'd98,    1'b1, 1'b0, 16'd0},
    '{ROW_BYTE, 16'd255,   1'b0, 1'b0, 16'd0},
    '{ROW_BYTE, 16'd255,   1'b0, 1'b0, 16'd0},
    '{ROW_BYTE, 16'd255,   1'b1, 1'b0, 16'd0},
    '{ROW_CFG,  16'd65535, 1'b0, 1'b0, 16'd0},
    '{ROW_BYTE, 16'd255,   1'b1, 1'b1, 16'd255},
    '{ROW_BYTE, 16'd0,     1'b0, 1'b0, 16'd0},
    '{ROW_BYTE, 16'd200,   1'b1, 1'b0, 16'd0},
    '{ROW_CFG,  16'd0,     1'b0, 1'b0, 16'd0},
    '{ROW_BYTE, 16'd255,   1'b1, 1'b1, 16'd1},
    '{ROW_BYTE, 16'd254,   1'b0, 1'b0, 16'd0},
    '{ROW_BYTE, 16'd1,     1'b1, 1'b0, 16'd0},
    '{ROW_CFG,  16'd1,     1'b0, 1'b0, 16'd0},
    '{ROW_BYTE, 16'd7,     1'b1, 1'b1, 16'd1},
    '{ROW_BYTE, 16'd128,   1'b1, 1'b1, 16'd0},
    '{ROW_CFG,  16'd2,     1'b0, 1'b0, 16'd0},
    '{ROW_BYTE, 16'd3,     1'b0, 1'b0, 16'd0},
    '{ROW_BYTE, 16'd5,     1'b0, 1'b0, 16'd0},
    '{ROW_BYTE, 16'd255,   1'b1, 1'b0, 16'd0},
    '{ROW_CFG,  16'd3,     1'b0, 1'b0, 16'd0},
    '{ROW_BYTE, 16'd255,   1'b1, 1'b1, 16'd0},
    '{ROW_BYTE, 16'd10,    1'b0, 1'b0, 16'd0},
    '{ROW_BYTE, 16'd20,    1'b1, 1'b0, 16'd0},
    '{ROW_CFG,  16'd919,   1'b0, 1'b0, 16'd0}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] character
  logic        s_axis_tlast  = 1'b0; // last_char
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [15:0] hash_value
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i    = '0;   // table_size

  int snd_idle_pct = 29;
  int rcv_idle_pct = 84;
  int errors       = 0;
  int quiet_cycles = 0;

  // model state
  logic [15:0] table_size_q = ush_pkg::TABLE_RESET;
  logic [15:0] acc_q        = '0;
  logic [15:0] mult_q       = ush_pkg::MULT_START;
  logic [15:0] bucket_q [$];

  universal_string_hash u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // absorb one byte; returns the hash after it
  function automatic logic [15:0] absorb_char(input logic [7:0] ch, input logic last);
    longint unsigned m;
    longint unsigned h;
    longint unsigned k;
    m = table_size_q;
    if (m < 2) m = 2;
    h = acc_q;
    k = mult_q;
    h = (h * k + ch) % m;
    k = (k * ush_pkg::MULT_STEP) % (m - 1);
    if (last) begin
      acc_q  = '0;
      mult_q = ush_pkg::MULT_START;
    end else begin
      acc_q  = h[15:0];
      mult_q = k[15:0];
    end
    return h[15:0];
  endfunction

  function automatic logic [15:0] pick_table_size();
    case ($urandom_range(5))
      0:       return 16'd2;
      1:       return 16'd65535;
      2:       return 16'($urandom_range(1));
      3:       return 16'($urandom_range(300, 2));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] ch, input logic last, input logic chk,
                           input logic [15:0] typed);
    logic [15:0] pred;
    if ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = absorb_char(ch, last);
    if (last) bucket_q.push_back(chk ? typed : pred);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (bucket_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_table_size(input logic [15:0] size);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= size;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i  <= 1'b0;
    table_size_q = size;
  endtask

  task automatic send_random_string(output int len);
    int style;
    logic [7:0] ch;
    len   = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
    style = $urandom_range(3);
    for (int i = 0; i < len; i++) begin
      ch = (style == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00) : 8'($urandom_range(255));
      send_byte(ch, i == len - 1, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk_i) begin : out_check
    logic [15:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (bucket_q.size() == 0) begin
        $error("hash_value: unexpected transfer, actual %0d", m_axis_tdata);
        errors++;
      end else begin
        want = bucket_q.pop_front();
        if (m_axis_tdata !== want) begin
          $error("hash_value: expected %0d, actual %0d", want, m_axis_tdata);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int sent;
    int len;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        write_table_size(DIRECTED[i].value);
      end else begin
        send_byte(DIRECTED[i].value[7:0], DIRECTED[i].last, DIRECTED[i].chk,
                  DIRECTED[i].bucket);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          snd_idle_pct = 29;
          rcv_idle_pct = 84;
        end
        1: begin
          snd_idle_pct = 84;
          rcv_idle_pct = 29;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < 3; s++) begin
        write_table_size(pick_table_size());
        sent = 0;
        while (sent < ITEMS_PER_SETTING) begin
          send_random_string(len);
          sent += len;
          // hold off the sender until the output side has caught up
          if ($urandom_range(19) == 0 ||
              (sent >= ITEMS_PER_SETTING / 2 && sent - len < ITEMS_PER_SETTING / 2)) begin
            wait_drained();
          end
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
